[rtl/core/tms_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tms_pkg
// Shared types and constants of the single-tape turing machine stepper.
// ----------------------------------------------------------------------------
package tms_pkg;

	localparam int unsigned DATA_W = 56;

	typedef enum logic [2:0] {
		ACT_LOAD_RULE  = 3'd0,
		ACT_WRITE_CELL = 3'd1,
		ACT_START_RUN  = 3'd2,
		ACT_STEP       = 3'd3,
		ACT_READ_CELL  = 3'd4
	} action_t;

	typedef enum logic [2:0] {
		STS_RUNNING = 3'd0,
		STS_HALTED  = 3'd1,
		STS_TIMEOUT = 3'd2,
		STS_MISSING = 3'd3,
		STS_OFFTAPE = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		MOVE_LEFT  = 2'd0,
		MOVE_RIGHT = 2'd1,
		MOVE_STAY  = 2'd2,
		MOVE_HALT  = 2'd3
	} move_t;

	typedef enum logic [2:0] {
		FSM_CLEAR,
		FSM_IDLE,
		FSM_TAPE,
		FSM_RULE,
		FSM_RESP
	} fsm_t;

	typedef struct packed {
		logic       valid;
		logic [9:0] next_state;
		logic [5:0] write_symbol;
		move_t      move;
	} rule_entry_t;

	localparam logic [0:0]  CFG_STEP_LIMIT    = 1'd0;
	localparam logic [0:0]  CFG_BLANK_SYMBOL  = 1'd1;
	localparam logic [19:0] STEP_LIMIT_RESET  = 20'd1000000;
	localparam logic [5:0]  TAPE_RESET_SYMBOL = 6'd33;

endpackage

[rtl/core/tms_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tms_ram
// Simple dual-port RAM, one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module tms_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/core/turing_machine_stepper.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// turing_machine_stepper
// Single-tape turing machine: rule memory and tape memory with a step engine.
//
// channel  dir  fields (lsb first)
// s_*      in   action, rule_state, rule_symbol, next_state, write_symbol,
//               head_move, cell_index, cell_symbol
// m_*      out  status, machine_state, head_position, step_count, read_symbol
// cfg_*    in   0 step_limit, 1 blank_symbol
//
// a running step goes through accept, tape read, rule read and result register; a cell read,
// or a step whose state or symbol is out of range, skips the rule read; every other item goes
// from accept to the result register (stopped or at-limit steps too); one item at a time
// after reset both memories are swept, max(rule depth, TAPE_CELLS) cells (65536 by default)
// with s_tready low; a result waits in the output register while m_tready is low and the
// engine holds in its result state until the register is free
// ----------------------------------------------------------------------------
module turing_machine_stepper #(
	parameter int unsigned NUM_STATES  = 1024,
	parameter int unsigned NUM_SYMBOLS = 64,
	parameter int unsigned TAPE_CELLS  = 4096
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// action, rule_state, rule_symbol, next_state, write_symbol, head_move,
	// cell_index, cell_symbol, zero pad
	input  logic [tms_pkg::DATA_W-1:0] s_tdata,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// status, machine_state, head_position, step_count, read_symbol, zero pad
	output logic [tms_pkg::DATA_W-1:0] m_tdata,
	input  logic                       cfg_we,
	input  logic [0:0]                 cfg_index,
	input  logic [19:0]                cfg_wdata
);

	localparam int unsigned SW         = $clog2(NUM_STATES);
	localparam int unsigned YW         = $clog2(NUM_SYMBOLS);
	localparam int unsigned RAW        = SW + YW;
	localparam int unsigned RULE_DEPTH = 1 << RAW;
	localparam int unsigned TW         = $clog2(TAPE_CELLS);
	localparam int unsigned CLR_LEN    = (RULE_DEPTH > TAPE_CELLS) ? RULE_DEPTH : TAPE_CELLS;
	localparam int unsigned CW         = $clog2(CLR_LEN);
	localparam int unsigned RW         = $bits(tms_pkg::rule_entry_t);

	localparam logic [12:0] NUM_STATES_C  = 13'(NUM_STATES);
	localparam logic [6:0]  NUM_SYMBOLS_C = 7'(NUM_SYMBOLS);
	localparam logic [16:0] TAPE_CELLS_C  = 17'(TAPE_CELLS);
	localparam logic [TW-1:0] LAST_CELL   = TW'(TAPE_CELLS - 1);
	localparam logic [CW:0] RULE_DEPTH_C  = (CW+1)'(RULE_DEPTH);
	localparam logic [CW:0] TAPE_DEPTH_C  = (CW+1)'(TAPE_CELLS);
	localparam logic [CW-1:0] CLR_LAST    = CW'(CLR_LEN - 1);

	// input fields
	tms_pkg::action_t in_action;
	logic [9:0]       in_rule_state;
	logic [5:0]       in_rule_symbol;
	logic [9:0]       in_next_state;
	logic [5:0]       in_write_symbol;
	tms_pkg::move_t   in_head_move;
	logic [11:0]      in_cell_index;
	logic [5:0]       in_cell_symbol;

	assign in_action       = tms_pkg::action_t'(s_tdata[2:0]);
	assign in_rule_state   = s_tdata[12:3];
	assign in_rule_symbol  = s_tdata[18:13];
	assign in_next_state   = s_tdata[28:19];
	assign in_write_symbol = s_tdata[34:29];
	assign in_head_move    = tms_pkg::move_t'(s_tdata[36:35]);
	assign in_cell_index   = s_tdata[48:37];
	assign in_cell_symbol  = s_tdata[54:49];

	tms_pkg::fsm_t    fsm_q, fsm_d;
	logic [CW-1:0]    clr_cnt_q;
	logic [9:0]       state_q;
	logic [TW-1:0]    head_q;
	logic [19:0]      steps_q;
	tms_pkg::status_t status_q;
	logic [19:0]      limit_q;
	logic             out_valid_q;
	logic [tms_pkg::DATA_W-1:0] out_data_q;
	tms_pkg::action_t act_q;
	logic             cell_ok_q;
	logic [5:0]       rd_q;

	logic accept;
	logic out_load;
	logic clr_done;
	logic run_ok;
	logic in_cell_ok;
	logic in_rule_ok;
	logic sym_ok;
	logic [16:0] in_cell_ext;
	logic [11:0] in_rs_ext;
	logic [11:0] state_ext;
	logic [16:0] head_ext;
	logic [RAW-1:0] rule_load_addr;
	logic [RAW-1:0] rule_look_addr;

	// memory ports
	logic              tape_we;
	logic [TW-1:0]     tape_waddr;
	logic [5:0]        tape_wdata;
	logic [TW-1:0]     tape_raddr;
	logic [5:0]        tape_rdata;
	logic              rule_we;
	logic [RAW-1:0]    rule_waddr;
	logic [RW-1:0]     rule_wdata;
	logic [RW-1:0]     rule_rdata;
	tms_pkg::rule_entry_t rule_entry;
	tms_pkg::rule_entry_t rule_new;

	assign accept      = s_tvalid && s_tready;
	assign clr_done    = (clr_cnt_q == CLR_LAST);
	assign run_ok      = (status_q == tms_pkg::STS_RUNNING) && (steps_q < limit_q);
	assign in_cell_ext = 17'(in_cell_index);
	assign in_cell_ok  = (in_cell_ext < TAPE_CELLS_C);
	assign in_rs_ext   = 12'(in_rule_state);
	assign in_rule_ok  = (13'(in_rule_state) < NUM_STATES_C) &&
		(7'(in_rule_symbol) < NUM_SYMBOLS_C);
	assign state_ext   = 12'(state_q);
	assign sym_ok      = (13'(state_q) < NUM_STATES_C) && (7'(tape_rdata) < NUM_SYMBOLS_C);
	assign head_ext    = 17'(head_q);
	assign rule_load_addr = {in_rs_ext[SW-1:0], in_rule_symbol[YW-1:0]};
	assign rule_look_addr = {state_ext[SW-1:0], tape_rdata[YW-1:0]};
	assign rule_entry  = tms_pkg::rule_entry_t'(rule_rdata);

	always_comb begin
		rule_new.valid        = 1'b1;
		rule_new.next_state   = in_next_state;
		rule_new.write_symbol = in_write_symbol;
		rule_new.move         = in_head_move;
	end

	tms_ram #(
		.WIDTH(6),
		.DEPTH(TAPE_CELLS)
	) u_tape (
		.clk  (clk),
		.we   (tape_we),
		.waddr(tape_waddr),
		.wdata(tape_wdata),
		.raddr(tape_raddr),
		.rdata(tape_rdata)
	);

	tms_ram #(
		.WIDTH(RW),
		.DEPTH(RULE_DEPTH)
	) u_rules (
		.clk  (clk),
		.we   (rule_we),
		.waddr(rule_waddr),
		.wdata(rule_wdata),
		.raddr(rule_look_addr),
		.rdata(rule_rdata)
	);

	// next state
	always_comb begin
		fsm_d = fsm_q;
		case (fsm_q)
			tms_pkg::FSM_CLEAR: begin
				if (clr_done) begin
					fsm_d = tms_pkg::FSM_IDLE;
				end
			end
			tms_pkg::FSM_IDLE: begin
				if (accept) begin
					if ((in_action == tms_pkg::ACT_STEP && run_ok) ||
						in_action == tms_pkg::ACT_READ_CELL) begin
						fsm_d = tms_pkg::FSM_TAPE;
					end else begin
						fsm_d = tms_pkg::FSM_RESP;
					end
				end
			end
			tms_pkg::FSM_TAPE: begin
				if (act_q == tms_pkg::ACT_STEP && sym_ok) begin
					fsm_d = tms_pkg::FSM_RULE;
				end else begin
					fsm_d = tms_pkg::FSM_RESP;
				end
			end
			tms_pkg::FSM_RULE: begin
				fsm_d = tms_pkg::FSM_RESP;
			end
			tms_pkg::FSM_RESP: begin
				if (out_load) begin
					fsm_d = tms_pkg::FSM_IDLE;
				end
			end
			default: begin
				fsm_d = tms_pkg::FSM_IDLE;
			end
		endcase
	end

	// memory and handshake controls
	always_comb begin
		s_tready   = 1'b0;
		out_load   = 1'b0;
		tape_we    = 1'b0;
		tape_waddr = head_q;
		tape_wdata = rule_entry.write_symbol;
		tape_raddr = head_q;
		rule_we    = 1'b0;
		rule_waddr = rule_load_addr;
		rule_wdata = rule_new;
		case (fsm_q)
			tms_pkg::FSM_CLEAR: begin
				tape_we    = ({1'b0, clr_cnt_q} < TAPE_DEPTH_C);
				tape_waddr = clr_cnt_q[TW-1:0];
				tape_wdata = tms_pkg::TAPE_RESET_SYMBOL;
				rule_we    = ({1'b0, clr_cnt_q} < RULE_DEPTH_C);
				rule_waddr = clr_cnt_q[RAW-1:0];
				rule_wdata = '0;
			end
			tms_pkg::FSM_IDLE: begin
				s_tready = 1'b1;
				if (in_action == tms_pkg::ACT_READ_CELL) begin
					tape_raddr = in_cell_ext[TW-1:0];
				end
				if (s_tvalid && in_action == tms_pkg::ACT_LOAD_RULE && in_rule_ok) begin
					rule_we = 1'b1;
				end
				if (s_tvalid && in_action == tms_pkg::ACT_WRITE_CELL && in_cell_ok) begin
					tape_we    = 1'b1;
					tape_waddr = in_cell_ext[TW-1:0];
					tape_wdata = in_cell_symbol;
				end
			end
			tms_pkg::FSM_RULE: begin
				// write the rule's symbol into the cell under the head
				tape_we = rule_entry.valid;
			end
			tms_pkg::FSM_RESP: begin
				out_load = !out_valid_q || m_tready;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q       <= tms_pkg::FSM_CLEAR;
			clr_cnt_q   <= '0;
			state_q     <= '0;
			head_q      <= '0;
			steps_q     <= '0;
			status_q    <= tms_pkg::STS_RUNNING;
			limit_q     <= tms_pkg::STEP_LIMIT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			fsm_q <= fsm_d;
			if (fsm_q == tms_pkg::FSM_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			// a blank_symbol write is ignored; it never changes stored cells
			if (cfg_we && cfg_index == tms_pkg::CFG_STEP_LIMIT) begin
				limit_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (accept && in_action == tms_pkg::ACT_START_RUN) begin
				state_q <= '0;
				steps_q <= '0;
				if (in_cell_ok) begin
					head_q   <= in_cell_ext[TW-1:0];
					status_q <= tms_pkg::STS_RUNNING;
				end else begin
					head_q   <= '0;
					status_q <= tms_pkg::STS_OFFTAPE;
				end
			end
			if (accept && in_action == tms_pkg::ACT_STEP &&
				status_q == tms_pkg::STS_RUNNING && !run_ok) begin
				status_q <= tms_pkg::STS_TIMEOUT;
			end
			if (fsm_q == tms_pkg::FSM_TAPE && act_q == tms_pkg::ACT_STEP && !sym_ok) begin
				status_q <= tms_pkg::STS_MISSING;
			end
			if (fsm_q == tms_pkg::FSM_RULE) begin
				if (!rule_entry.valid) begin
					status_q <= tms_pkg::STS_MISSING;
				end else begin
					state_q <= rule_entry.next_state;
					case (rule_entry.move)
						tms_pkg::MOVE_HALT: begin
							status_q <= tms_pkg::STS_HALTED;
						end
						tms_pkg::MOVE_LEFT: begin
							steps_q <= steps_q + 1'b1;
							if (head_q == '0) begin
								status_q <= tms_pkg::STS_OFFTAPE;
							end else begin
								head_q <= head_q - 1'b1;
							end
						end
						tms_pkg::MOVE_RIGHT: begin
							steps_q <= steps_q + 1'b1;
							if (head_q == LAST_CELL) begin
								status_q <= tms_pkg::STS_OFFTAPE;
							end else begin
								head_q <= head_q + 1'b1;
							end
						end
						default: begin
							steps_q <= steps_q + 1'b1;
						end
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q     <= in_action;
			cell_ok_q <= in_cell_ok;
			rd_q      <= '0;
		end
		if (fsm_q == tms_pkg::FSM_TAPE && act_q == tms_pkg::ACT_READ_CELL) begin
			rd_q <= cell_ok_q ? tape_rdata : 6'd0;
		end
		if (out_load) begin
			out_data_q <= {5'd0, rd_q, steps_q, head_ext[11:0], state_q, status_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// assertions
	a_step_enters_tape: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_action == tms_pkg::ACT_STEP && run_ok) |=> (fsm_q == tms_pkg::FSM_TAPE))
		else $error("accepted step did not issue a tape read");

	a_head_on_tape: assert property (@(posedge clk) disable iff (!arst_n)
		(head_ext < TAPE_CELLS_C))
		else $error("head left the tape range");

	a_steps_source: assert property (@(posedge clk) disable iff (!arst_n)
		(steps_q != $past(steps_q)) |->
		($past(fsm_q) == tms_pkg::FSM_RULE ||
		($past(accept) && $past(in_action) == tms_pkg::ACT_START_RUN)))
		else $error("step count changed outside a step or run start");

	a_result_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> ($past(fsm_q) == tms_pkg::FSM_RESP))
		else $error("result appeared without a finished transaction");

endmodule
